// ===== rtl/ectt_pkg.sv =====
// shared types and constants for the encoder count to tape time block
// no dependencies
package ectt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SCALE = 1'b0;
   localparam logic [31:0] SCALE_RESET = 32'd4475175;

   localparam int DAY_SECONDS    = 86400;
   localparam int HOUR_SECONDS   = 3600;
   localparam int MINUTE_SECONDS = 60;
   localparam int TENTHS_PER_SEC = 10;
   localparam int FRAMES_PER_SEC = 30;

   // reciprocal constants: q = ((x >> PRE) * RECIP) >> SHIFT, exact over the value range
   localparam int DAY_PRE     = 7;
   localparam int DAY_SHIFT   = 35;
   localparam int RECIP_DAY   = 50903317;
   localparam int HOUR_PRE    = 4;
   localparam int HOUR_SHIFT  = 20;
   localparam int RECIP_HOUR  = 4661;
   localparam int MIN_PRE     = 2;
   localparam int MIN_SHIFT   = 14;
   localparam int RECIP_MIN   = 1093;

   typedef struct packed {
      logic [31:0] magnitude;
      logic        fast;
      logic        positive;
   } entry_type;

   typedef struct packed {
      logic [3:0] tenths;
      logic [4:0] frames;
      logic       positive;
   } side_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] whole_seconds;
      logic [3:0] tenths;
      logic [4:0] frames;
      logic       positive;
   } result_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ===== rtl/ectt_csr.sv =====
// configuration register file, apb-style write and read
// depends on ectt_pkg
module ectt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ectt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ectt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ectt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [31:0]                    scale
);
   import ectt_pkg::*;

   logic [31:0] scale_ff;
   logic [31:0] scale_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      scale_in = scale_ff;
      if (wr_en && csr_paddr[2] == CSR_IDX_SCALE) begin
         scale_in = csr_pwdata[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_SCALE: csr_prdata = scale_ff;
         default:       csr_prdata = '0;
      endcase
   end

   assign scale = scale_ff;

endmodule

// ===== rtl/ectt_front.sv =====
// front end: takes the count apart into magnitude, sign and speed
// depends on ectt_pkg
module ectt_front (
   input  logic                req_tvalid,
   input  logic [31:0]         req_tdata,
   input  logic                req_tuser,
   output ectt_pkg::push_type  push
);
   import ectt_pkg::*;

   logic negative;

   assign negative = req_tdata[31];

   always_comb begin
      push.valid           = req_tvalid;
      push.entry.magnitude = negative ? (32'd0 - req_tdata) : req_tdata;
      push.entry.fast      = req_tuser;
      push.entry.positive  = ~negative;
   end

endmodule

// ===== rtl/ectt_queue.sv =====
// short request queue between front and back end
// depends on ectt_pkg
module ectt_queue (
   input  logic                clock,
   input  logic                reset,
   input  ectt_pkg::push_type  push,
   output logic                push_ready,
   output logic                pop_valid,
   output ectt_pkg::entry_type pop_entry,
   input  logic                pop
);
   import ectt_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCOUNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== rtl/ectt_back.sv =====
// back end: scale multiply, day wrap and time split pipeline with output register
// depends on ectt_pkg
module ectt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ectt_pkg::entry_type  q_entry,
   output logic                 q_pop,
   input  logic [31:0]          scale,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output ectt_pkg::result_type rsp_result
);
   import ectt_pkg::*;

   logic       en;
   logic [6:0] valid_ff, valid_in;

   logic [63:0] prod_t;
   logic [63:0] s1_t_ff, s1_t_in;
   logic        s1_pos_ff;

   logic [50:0] prod_day;
   logic [35:0] prod_ten;
   logic [36:0] prod_frm;
   logic [31:0] s2_secs_ff;
   logic [15:0] s2_quot_ff, s2_quot_in;
   side_type    s2_side_ff, s2_side_in;

   logic [32:0] day_mul, day_diff;
   logic [16:0] s3_day_ff, s3_day_in;
   side_type    s3_side_ff;

   logic [25:0] prod_hour;
   logic [16:0] s4_day_ff;
   logic [4:0]  s4_hours_ff, s4_hours_in;
   side_type    s4_side_ff;

   logic [16:0] hour_mul, hour_diff;
   logic [4:0]  s5_hours_ff;
   logic [11:0] s5_rem_ff, s5_rem_in;
   side_type    s5_side_ff;

   logic [20:0] prod_min;
   logic [4:0]  s6_hours_ff;
   logic [11:0] s6_rem_ff;
   logic [5:0]  s6_min_ff, s6_min_in;
   side_type    s6_side_ff;

   logic [11:0] min_mul, min_diff;
   result_type  out_ff, out_in;

   assign en    = ~valid_ff[6] | rsp_ready;
   assign q_pop = en;
   assign valid_in = {valid_ff[5:0], q_valid};

   // stage 1: scale multiply, doubled at slow speed
   always_comb begin
      prod_t  = 64'(q_entry.magnitude) * 64'(scale);
      s1_t_in = q_entry.fast ? prod_t : {prod_t[62:0], 1'b0};
   end

   // stage 2: day quotient and fraction digits
   always_comb begin
      prod_day = 51'(s1_t_ff[63:32] >> DAY_PRE) * 51'(RECIP_DAY);
      s2_quot_in = prod_day[DAY_SHIFT+15:DAY_SHIFT];
      prod_ten = 36'(s1_t_ff[31:0]) * 36'(TENTHS_PER_SEC);
      prod_frm = 37'(s1_t_ff[31:0]) * 37'(FRAMES_PER_SEC);
      s2_side_in.tenths   = prod_ten[35:32];
      s2_side_in.frames   = prod_frm[36:32];
      s2_side_in.positive = s1_pos_ff;
   end

   // stage 3: seconds within the day
   always_comb begin
      day_mul   = 33'(s2_quot_ff) * 33'(DAY_SECONDS);
      day_diff  = {1'b0, s2_secs_ff} - day_mul;
      s3_day_in = day_diff[16:0];
   end

   // stage 4: hours
   always_comb begin
      prod_hour   = 26'(s3_day_ff >> HOUR_PRE) * 26'(RECIP_HOUR);
      s4_hours_in = prod_hour[HOUR_SHIFT+4:HOUR_SHIFT];
   end

   // stage 5: seconds within the hour
   always_comb begin
      hour_mul  = 17'(s4_hours_ff) * 17'(HOUR_SECONDS);
      hour_diff = s4_day_ff - hour_mul;
      s5_rem_in = hour_diff[11:0];
   end

   // stage 6: minutes
   always_comb begin
      prod_min  = 21'(s5_rem_ff >> MIN_PRE) * 21'(RECIP_MIN);
      s6_min_in = prod_min[MIN_SHIFT+5:MIN_SHIFT];
   end

   // output: seconds within the minute
   always_comb begin
      min_mul  = 12'(s6_min_ff) * 12'(MINUTE_SECONDS);
      min_diff = s6_rem_ff - min_mul;
      out_in.hours         = s6_hours_ff;
      out_in.minutes       = s6_min_ff;
      out_in.whole_seconds = min_diff[5:0];
      out_in.tenths        = s6_side_ff.tenths;
      out_in.frames        = s6_side_ff.frames;
      out_in.positive      = s6_side_ff.positive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_t_ff     <= s1_t_in;
         s1_pos_ff   <= q_entry.positive;
         s2_secs_ff  <= s1_t_ff[63:32];
         s2_quot_ff  <= s2_quot_in;
         s2_side_ff  <= s2_side_in;
         s3_day_ff   <= s3_day_in;
         s3_side_ff  <= s2_side_ff;
         s4_day_ff   <= s3_day_ff;
         s4_hours_ff <= s4_hours_in;
         s4_side_ff  <= s3_side_ff;
         s5_hours_ff <= s4_hours_ff;
         s5_rem_ff   <= s5_rem_in;
         s5_side_ff  <= s4_side_ff;
         s6_hours_ff <= s5_hours_ff;
         s6_rem_ff   <= s5_rem_ff;
         s6_min_ff   <= s6_min_in;
         s6_side_ff  <= s5_side_ff;
         out_ff      <= out_in;
      end
   end

   assign rsp_valid  = valid_ff[6];
   assign rsp_result = out_ff;

endmodule

// ===== rtl/encoder_count_to_tape_time_core.sv =====
// Encoder count to tape time converter, top level.
// depends on ectt_pkg, ectt_csr, ectt_front, ectt_queue, ectt_back
//
// Request channel (req_): a signed 32-bit encoder count in tdata and the speed
// select in tuser (1 = 30 ips, 0 = 15 ips, scale doubled). Response channel
// (rsp_): one tape time per request, hours, minutes and seconds of the day
// wrapped time plus tenths and frames of the fraction, and the count's sign.
// Configuration: one apb register at byte address 0, the Q0.32 seconds per
// tick at 30 ips; write it only while the block is idle.
// A request waits in the queue and then passes through the seven-stage back end
// (scale multiply, three reciprocal divides and their remainders, output
// register) before rsp_tvalid rises.
// Throughput: one request per cycle while the receiver is not stalling the
// output register, bounded by the single 32x32 multiplier stage.
// Reset clears the queue and all stage valid bits and loads the scale reset
// value. When the receiver stalls, the back end holds and the four-entry
// queue keeps accepting until it fills, then req_tready drops.
module encoder_count_to_tape_time_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // position
   input  logic                           req_tuser,   // speed_fast
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // hours, minutes, whole_seconds, tenths, frames, zero fill
   output logic [31:0]                    rsp_tdata,
   output logic                           rsp_tuser,   // positive
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ectt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ectt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ectt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ectt_pkg::*;

   logic        [31:0] scale;
   push_type           push;
   logic               q_valid;
   entry_type          q_entry;
   logic               q_pop;
   result_type         result;

   ectt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .scale       (scale)
   );

   ectt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push)
   );

   ectt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (req_tready),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .pop        (q_pop)
   );

   ectt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .scale      (scale),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (result)
   );

   assign rsp_tdata = {6'd0, result.frames, result.tenths, result.whole_seconds,
                       result.minutes, result.hours};
   assign rsp_tuser = result.positive;

endmodule

// ===== dv/encoder_count_to_tape_time_core_tb.sv =====
// testbench for encoder_count_to_tape_time_core: streams encoder counts, predicts tape time
// per request and checks each response field; walks the scale register through several values
// depends on ectt_pkg and the encoder_count_to_tape_time_core rtl
module encoder_count_to_tape_time_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ectt_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SCALE = {CSR_IDX_SCALE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = 3'd4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_REQUESTS  = 170;
   localparam int DRAIN_CYCLES    = 12;
   localparam int REPORT_LIMIT    = 40;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic [31:0] position;
      logic        fast;
   } count_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // position
   logic        req_tuser = 1'b0; // speed_fast
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // hours, minutes, whole_seconds, tenths, frames, zero fill
   logic        rsp_tuser;        // positive
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   count_request_type pending_counts[$];
   result_type        expected_times[$];
   logic [31:0]       scale_fast = SCALE_RESET;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   encoder_count_to_tape_time_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic result_type tape_time_of(logic [31:0] position, logic fast,
                                               logic [31:0] scale);
      result_type  r;
      logic [31:0] magnitude;
      logic [63:0] product;
      logic [31:0] day_secs;
      logic [63:0] fraction;
      magnitude = position[31] ? (32'd0 - position) : position;
      product   = {32'd0, magnitude} * {32'd0, scale};
      if (!fast) begin
         product = product << 1;
      end
      day_secs  = product[63:32] % DAY_SECONDS;
      fraction  = {32'd0, product[31:0]};
      r.hours         = 5'(day_secs / HOUR_SECONDS);
      r.minutes       = 6'((day_secs % HOUR_SECONDS) / MINUTE_SECONDS);
      r.whole_seconds = 6'(day_secs % MINUTE_SECONDS);
      r.tenths        = 4'((fraction * TENTHS_PER_SEC) >> 32);
      r.frames        = 5'((fraction * FRAMES_PER_SEC) >> 32);
      r.positive      = ~position[31];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      count_request_type next_count;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_times.push_back(tape_time_of(req_tdata, req_tuser, scale_fast));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_counts.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_count = pending_counts.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_count.position;
               req_tuser  <= next_count.fast;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and watchdog
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_times.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, 32'd0);
            end else begin
               want = expected_times.pop_front();
               if (rsp_tdata[4:0] != want.hours)
                  report_mismatch("hours", 32'(rsp_tdata[4:0]), 32'(want.hours));
               if (rsp_tdata[10:5] != want.minutes)
                  report_mismatch("minutes", 32'(rsp_tdata[10:5]), 32'(want.minutes));
               if (rsp_tdata[16:11] != want.whole_seconds)
                  report_mismatch("whole_seconds", 32'(rsp_tdata[16:11]),
                                  32'(want.whole_seconds));
               if (rsp_tdata[20:17] != want.tenths)
                  report_mismatch("tenths", 32'(rsp_tdata[20:17]), 32'(want.tenths));
               if (rsp_tdata[25:21] != want.frames)
                  report_mismatch("frames", 32'(rsp_tdata[25:21]), 32'(want.frames));
               if (rsp_tuser != want.positive)
                  report_mismatch("positive", 32'(rsp_tuser), 32'(want.positive));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (pending_counts.size() == 0 && !req_tvalid && expected_times.size() == 0)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL encoder_count_to_tape_time_core");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic csr_access(logic write, logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= write;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (write && addr == ADDR_SCALE) begin
         scale_fast = value;
      end
      if (!write && addr == ADDR_SCALE && csr_prdata != scale_fast) begin
         report_mismatch("scale readback", csr_prdata, scale_fast);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_counts.size() != 0 || req_tvalid || expected_times.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0]   directed_positions[10];
      logic [31:0]   phase_scale;
      logic [31:0]   position;
      idle_mode_type mode;
      directed_positions = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'd960, 32'd82944000, 32'd82944960, 32'hFB0E_8000,
                             32'd3455999};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, ADDR_SCALE, '0);

      // directed: field extremes, sign edges and day wrap at the reset scale
      foreach (directed_positions[i]) begin
         pending_counts.push_back('{directed_positions[i], 1'b1});
         pending_counts.push_back('{directed_positions[i], 1'b0});
      end
      wait_drained();

      // write to an unmapped address is ignored
      csr_access(1'b1, ADDR_SPARE, $urandom);
      csr_access(1'b0, ADDR_SCALE, '0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: phase_scale = 32'h0000_0000;
            1: phase_scale = 32'hFFFF_FFFF;
            2: phase_scale = 32'd1;
            3: phase_scale = SCALE_RESET;
            4: phase_scale = 32'h8000_0000;
            default: phase_scale = $urandom;
         endcase
         csr_access(1'b1, ADDR_SCALE, phase_scale);
         csr_access(1'b0, ADDR_SCALE, '0);
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
               sender_idle_pct = 46;
               receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 46;
            end
            default: begin
               sender_idle_pct = 16;
               receiver_stall_pct = 16;
            end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            case ($urandom_range(9))
               0: begin
                  case ($urandom_range(4))
                     0: position = 32'd0;
                     1: position = 32'd1;
                     2: position = 32'hFFFF_FFFF;
                     3: position = 32'h7FFF_FFFF;
                     default: position = 32'h8000_0000;
                  endcase
               end
               1, 2, 3: position = 32'($urandom_range(400000)) - 32'd200000;
               default: position = $urandom;
            endcase
            pending_counts.push_back('{position, 1'($urandom_range(1))});
         end
         wait_drained();
      end

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_times.size() == 0) begin
         $display("PASS encoder_count_to_tape_time_core");
      end else begin
         $display("FAIL encoder_count_to_tape_time_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ectt_pkg.sv
rtl/ectt_csr.sv
rtl/ectt_front.sv
rtl/ectt_queue.sv
rtl/ectt_back.sv
rtl/encoder_count_to_tape_time_core.sv
dv/encoder_count_to_tape_time_core_tb.sv
